// ----- hdl/cra_pkg.sv -----
// shared types and constants for the crandall residue alu
`default_nettype none

package cra_pkg;

  // fixed field widths of the transaction ports
  localparam int FIELD_W = 52;
  localparam int RES_W   = 53;
  localparam int K_W     = 12;
  localparam int CMD_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/cra_fold.sv -----
// one crandall fold: low bits plus the bits above the modulus width times k
`default_nettype none

module cra_fold #(
  parameter int MODULUS_BITS = 52,
  parameter int IN_W         = 64,
  parameter int OUT_W        = 53
) (
  input  wire logic [IN_W-1:0]          word,
  input  wire logic [cra_pkg::K_W-1:0]  k,
  output logic      [OUT_W-1:0]         folded
);

  localparam int HI_W   = IN_W - MODULUS_BITS;
  localparam int PROD_W = HI_W + cra_pkg::K_W;
  localparam int SUM_W  = ((PROD_W > MODULUS_BITS) ? PROD_W : MODULUS_BITS) + 1;

  logic [PROD_W-1:0] hi_k;
  logic [SUM_W-1:0]  sum;

  assign hi_k   = PROD_W'(word[IN_W-1:MODULUS_BITS]) * PROD_W'(k);
  assign sum    = SUM_W'(word[MODULUS_BITS-1:0]) + SUM_W'(hi_k);
  assign folded = sum[OUT_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/crandall_residue_alu_unit.sv -----
// crandall residue alu: pipelined add, subtract and multiply modulo 2^n - k
//
// usage
//   one residue lane of an rns datapath. a transaction on the in_ channel
//   carries a command (add, subtract, multiply), two residues, the crandall
//   constant k and the channel modulus. each transaction gives exactly one
//   transaction on the out_ channel: a partly reduced residue (below
//   2^MODULUS_BITS + k) and an underflow flag for a subtract whose
//   subtrahend exceeds a plus the modulus (residue then 0).
// pipeline and throughput
//   six register stages; stage 6 is the output register on the out_ ports.
//   one transaction per cycle sustained while out_ready stays high. the
//   stage depth is set by the multiply path: four limb products, the
//   product sum, the hi*k multiply, the lo + hi*k add and two folds.
// reset
//   rst_n is synchronous, active low; it empties every stage, payload
//   registers keep whatever they held.
// stalls
//   when out_ready is low the result holds on the out_ ports and bubbles
//   in the pipe are squeezed out; in_ready drops only once every stage
//   holds a transaction. nothing is dropped or repeated.
`default_nettype none

module crandall_residue_alu_unit #(
  parameter int MODULUS_BITS = 52
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cra_pkg::CMD_W-1:0]   in_command,
  input  wire logic [cra_pkg::FIELD_W-1:0] in_operand_a,
  input  wire logic [cra_pkg::FIELD_W-1:0] in_operand_b,
  input  wire logic [cra_pkg::K_W-1:0]     in_crandall_k,
  input  wire logic [cra_pkg::FIELD_W-1:0] in_modulus,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cra_pkg::RES_W-1:0]        out_residue,
  output logic                             out_underflow
);

  localparam int MB     = MODULUS_BITS;
  localparam int KW     = cra_pkg::K_W;
  // limb split of the operands for the partial products
  localparam int LIMB_L = (MB + 1) / 2;
  localparam int LIMB_H = MB - LIMB_L;
  localparam int PW     = 2 * MB;        // full product width
  localparam int HKW    = MB + KW;       // hi*k and lo + hi*k width
  localparam int NST    = 6;

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage moves when it is empty or the next moves
  // ---------------------------------------------------------------------------
  logic [NST:1] vld_r;
  logic [NST:1] en;
  logic [NST:1] vin;
  logic [NST:1] ld;

  always_comb begin
    en[NST] = !vld_r[NST] || out_ready;
    for (int i = NST - 1; i >= 1; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign vin = {vld_r[NST-1:1], in_valid};
  assign ld  = en & vin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 1; i <= NST; i++) begin
        if (en[i]) begin
          vld_r[i] <= vin[i];
        end
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[NST];

  // ---------------------------------------------------------------------------
  // stage 1: limb products, a + b and a + m
  // ---------------------------------------------------------------------------
  logic [MB-1:0]          a_in, b_in, m_in;
  logic [LIMB_L-1:0]      a_lo, b_lo;
  logic [LIMB_H-1:0]      a_hi, b_hi;
  logic [2*LIMB_L-1:0]    pp00_nxt;
  logic [MB-1:0]          pp01_nxt, pp10_nxt;
  logic [2*LIMB_H-1:0]    pp11_nxt;
  logic [MB:0]            sum_nxt, am_nxt;

  // operand bits above the modulus width are ignored
  assign a_in = in_operand_a[MB-1:0];
  assign b_in = in_operand_b[MB-1:0];
  assign m_in = in_modulus[MB-1:0];

  assign a_lo = a_in[LIMB_L-1:0];
  assign a_hi = a_in[MB-1:LIMB_L];
  assign b_lo = b_in[LIMB_L-1:0];
  assign b_hi = b_in[MB-1:LIMB_L];

  assign pp00_nxt = (2*LIMB_L)'(a_lo) * (2*LIMB_L)'(b_lo);
  assign pp01_nxt = MB'(a_lo) * MB'(b_hi);
  assign pp10_nxt = MB'(a_hi) * MB'(b_lo);
  assign pp11_nxt = (2*LIMB_H)'(a_hi) * (2*LIMB_H)'(b_hi);
  assign sum_nxt  = (MB+1)'(a_in) + (MB+1)'(b_in);
  assign am_nxt   = (MB+1)'(a_in) + (MB+1)'(m_in);

  cra_pkg::cmd_t       cmd1_r;
  logic [2*LIMB_L-1:0] pp00_r;
  logic [MB-1:0]       pp01_r, pp10_r;
  logic [2*LIMB_H-1:0] pp11_r;
  logic [MB:0]         sum1_r, am1_r;
  logic [MB-1:0]       b1_r;
  logic [KW-1:0]       k1_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cmd1_r <= cra_pkg::cmd_t'(in_command);
      pp00_r <= pp00_nxt;
      pp01_r <= pp01_nxt;
      pp10_r <= pp10_nxt;
      pp11_r <= pp11_nxt;
      sum1_r <= sum_nxt;
      am1_r  <= am_nxt;
      b1_r   <= b_in;
      k1_r   <= in_crandall_k;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: full product, a + m - b with borrow, split into lo / hi
  // ---------------------------------------------------------------------------
  logic [PW-1:0]  prod_nxt;
  logic [MB+1:0]  diff_nxt;
  logic           borrow;
  logic [MB-1:0]  lo2_nxt, hi2_nxt;
  logic           uflow2_nxt;

  assign prod_nxt = PW'(pp00_r)
                  + (PW'(pp01_r) << LIMB_L)
                  + (PW'(pp10_r) << LIMB_L)
                  + (PW'(pp11_r) << (2 * LIMB_L));
  assign diff_nxt = (MB+2)'(am1_r) - (MB+2)'(b1_r);
  assign borrow   = diff_nxt[MB+1];

  // a zero lo / hi pair carries the forced-zero result of an underflow or
  // an unused command through the rest of the pipe
  always_comb begin
    lo2_nxt    = '0;
    hi2_nxt    = '0;
    uflow2_nxt = 1'b0;
    case (cmd1_r)
      cra_pkg::CMD_ADD: begin
        lo2_nxt = sum1_r[MB-1:0];
        hi2_nxt = MB'(sum1_r[MB]);
      end
      cra_pkg::CMD_SUB: begin
        uflow2_nxt = borrow;
        if (!borrow) begin
          lo2_nxt = diff_nxt[MB-1:0];
          hi2_nxt = MB'(diff_nxt[MB]);
        end
      end
      cra_pkg::CMD_MUL: begin
        lo2_nxt = prod_nxt[MB-1:0];
        hi2_nxt = prod_nxt[PW-1:MB];
      end
      default: begin
        lo2_nxt = '0;
        hi2_nxt = '0;
      end
    endcase
  end

  logic [MB-1:0] lo2_r, hi2_r;
  logic [KW-1:0] k2_r;
  logic          mul2_r, uflow2_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      lo2_r    <= lo2_nxt;
      hi2_r    <= hi2_nxt;
      k2_r     <= k1_r;
      mul2_r   <= (cmd1_r == cra_pkg::CMD_MUL);
      uflow2_r <= uflow2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: hi * k
  // ---------------------------------------------------------------------------
  logic [HKW-1:0] hk3_nxt;
  logic [HKW-1:0] hk3_r;
  logic [MB-1:0]  lo3_r;
  logic [KW-1:0]  k3_r;
  logic           mul3_r, uflow3_r;

  assign hk3_nxt = HKW'(hi2_r) * HKW'(k2_r);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      hk3_r    <= hk3_nxt;
      lo3_r    <= lo2_r;
      k3_r     <= k2_r;
      mul3_r   <= mul2_r;
      uflow3_r <= uflow2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: lo + hi*k (stays below 2^(MB+12) for in-range operands)
  // ---------------------------------------------------------------------------
  logic [HKW-1:0] r1_nxt;
  logic [HKW-1:0] r1_4_r;
  logic [KW-1:0]  k4_r;
  logic           mul4_r, uflow4_r;

  assign r1_nxt = HKW'(lo3_r) + hk3_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      r1_4_r   <= r1_nxt;
      k4_r     <= k3_r;
      mul4_r   <= mul3_r;
      uflow4_r <= uflow3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: first extra fold for multiply; add / subtract are done
  // ---------------------------------------------------------------------------
  logic [MB:0]   fold5;
  logic [MB:0]   r2_nxt;
  logic [MB:0]   r2_5_r;
  logic [KW-1:0] k5_r;
  logic          mul5_r, uflow5_r;

  cra_fold #(
    .MODULUS_BITS (MB),
    .IN_W         (HKW),
    .OUT_W        (MB + 1)
  ) u_fold_wide (
    .word   (r1_4_r),
    .k      (k4_r),
    .folded (fold5)
  );

  assign r2_nxt = mul4_r ? fold5 : r1_4_r[MB:0];

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      r2_5_r   <= r2_nxt;
      k5_r     <= k4_r;
      mul5_r   <= mul4_r;
      uflow5_r <= uflow4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: last fold for multiply, output register
  // ---------------------------------------------------------------------------
  logic [MB:0]                fold6;
  logic [MB:0]                r3_nxt;
  logic [cra_pkg::RES_W-1:0]  residue_r;
  logic                       underflow_r;

  cra_fold #(
    .MODULUS_BITS (MB),
    .IN_W         (MB + 1),
    .OUT_W        (MB + 1)
  ) u_fold_carry (
    .word   (r2_5_r),
    .k      (k5_r),
    .folded (fold6)
  );

  assign r3_nxt = mul5_r ? fold6 : r2_5_r;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      residue_r   <= cra_pkg::RES_W'(r3_nxt);
      underflow_r <= uflow5_r;
    end
  end

  assign out_residue   = residue_r;
  assign out_underflow = underflow_r;

endmodule

`default_nettype wire

// ----- hdl/cra_checker.sv -----
// port-level assertions for the crandall residue alu, bound to the top level
`default_nettype none

module cra_checker #(
  parameter int MODULUS_BITS = 52
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [cra_pkg::RES_W-1:0]   out_residue,
  input wire logic                        out_underflow
);

  localparam int BW = cra_pkg::RES_W + 1;
  localparam logic [BW-1:0] RES_BOUND =
    (BW'(1) << MODULUS_BITS) + (BW'(1) << cra_pkg::K_W);

  // an underflowing subtract always reports a zero residue
  a_uflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_underflow |-> out_residue == '0)
    else $error("underflow with nonzero residue");

  // results are partly reduced: below 2^n + 2^K_W
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> BW'(out_residue) < RES_BOUND)
    else $error("residue above partial reduction bound");

  // input back-pressure only comes from a stalled, occupied output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_residue) && $stable(out_underflow))
    else $error("stalled result changed");

endmodule

bind crandall_residue_alu_unit cra_checker #(
  .MODULUS_BITS (MODULUS_BITS)
) u_cra_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_residue   (out_residue),
  .out_underflow (out_underflow)
);

`default_nettype wire
